@@ hdl/vrc_pkg.sv @@
// Shared types, constants and helpers for the value-to-RGB colour map pipeline.
// Used by vrc_quant, vrc_shape, vrc_blend and value_to_rgb_colormap_top.
package vrc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FW        = FRAC_BITS + 1;
  localparam int IN_W      = 18;
  localparam int LEVEL_W   = 8;
  localparam int MODE_W    = 3;
  localparam int COLOUR_W  = 24;

  localparam logic [FW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FW-1:0] HALF = ONE >> 1;

  // Long division of the quantizer, a few quotient bits per pipeline stage.
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int QW         = DIV_STAGES * DIV_STEPS;
  localparam int QX         = QW - FRAC_BITS;

  localparam logic REG_PALETTE_MODE = 1'b0;
  localparam logic REG_LEVEL_COUNT  = 1'b1;

  // Palette families, selected by the upper two bits of the palette mode.
  localparam logic [1:0] PAL_BYR = 2'd0;
  localparam logic [1:0] PAL_GYR = 2'd1;
  localparam logic [1:0] PAL_BWB = 2'd2;
  localparam logic [1:0] PAL_RWB = 2'd3;

  localparam logic [COLOUR_W-1:0] COL_RED    = 24'hFF0000;
  localparam logic [COLOUR_W-1:0] COL_YELLOW = 24'hFFFF00;
  localparam logic [COLOUR_W-1:0] COL_BLUE   = 24'h0000FF;
  localparam logic [COLOUR_W-1:0] COL_GREEN  = 24'h00FF00;
  localparam logic [COLOUR_W-1:0] COL_WHITE  = 24'hFFFFFF;
  localparam logic [COLOUR_W-1:0] COL_BLACK  = 24'h000000;

  typedef struct packed {
    logic [MODE_W-1:0]  palette_mode;
    logic [LEVEL_W-1:0] level_count;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] rem;
    logic [QW-1:0]      quo;
  } div_state_t;

  // Several restoring division steps; a remainder below the divisor stays below it.
  function automatic div_state_t div_step(input div_state_t s, input logic [LEVEL_W-1:0] d);
    div_state_t       o;
    logic [LEVEL_W:0] r2;
    logic             qb;
    o = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r2 = {o.rem, 1'b0};
      qb = (r2 >= {1'b0, d});
      if (qb) begin
        r2 = r2 - {1'b0, d};
      end
      o.rem = r2[LEVEL_W-1:0];
      o.quo = {o.quo[QW-2:0], qb};
    end
    return o;
  endfunction

  // Start and end colour of the blend: the lower or upper half of the palette.
  function automatic logic [2*COLOUR_W-1:0] stop_pair(input logic [1:0] pal, input logic upper);
    logic [COLOUR_W-1:0] c0;
    logic [COLOUR_W-1:0] c1;
    logic [COLOUR_W-1:0] c2;
    unique case (pal)
      PAL_BYR: begin
        c0 = COL_RED;   c1 = COL_YELLOW; c2 = COL_BLUE;
      end
      PAL_GYR: begin
        c0 = COL_RED;   c1 = COL_YELLOW; c2 = COL_GREEN;
      end
      PAL_BWB: begin
        c0 = COL_BLACK; c1 = COL_WHITE;  c2 = COL_BLACK;
      end
      default: begin
        c0 = COL_RED;   c1 = COL_WHITE;  c2 = COL_BLUE;
      end
    endcase
    return upper ? {c1, c2} : {c0, c1};
  endfunction

endpackage

@@ hdl/vrc_quant.sv @@
// Front of the colour map pipeline: clamping, reversal and level quantization.
// The quantizer divides by (levels - 1) in a pipelined long divider. Uses vrc_pkg.
module vrc_quant
  import vrc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   in_valid,
  input  logic signed [IN_W-1:0] sample_value,
  input  cfg_t                   cfg,
  output logic                   out_valid,
  output logic [FW-1:0]          frac
);

  logic [FRAC_BITS+15:0] scaled;
  logic [FW-1:0]         clamped;
  logic [FW-1:0]         f_next;
  logic                  quant;
  logic [LEVEL_W-1:0]    divisor;

  logic                  valid1;
  logic [FW-1:0]         f1;
  logic [FW+LEVEL_W-1:0] kprod;
  logic                  valid2;
  logic [FW-1:0]         f2;
  logic [LEVEL_W-1:0]    k2;

  div_state_t            div_in    [DIV_STAGES];
  div_state_t            div_out   [DIV_STAGES];
  div_state_t            div_q     [DIV_STAGES];
  logic                  div_valid [DIV_STAGES];
  logic                  div_sat   [DIV_STAGES];
  logic [FW-1:0]         div_f     [DIV_STAGES];
  logic [QW-1:0]         quo_shifted;
  logic [FW-1:0]         fq_next;

  assign quant   = cfg.level_count > 8'd1;
  assign divisor = cfg.level_count - 8'd1;
  assign scaled  = {sample_value[15:0], {FRAC_BITS{1'b0}}};

  always_comb begin
    priority if (sample_value[IN_W-1]) begin
      clamped = '0;
    end else if (sample_value[16]) begin
      clamped = ONE;
    end else begin
      clamped = {1'b0, scaled[FRAC_BITS+15:16]};
    end
    // Even palette modes run the gradient backwards.
    f_next = cfg.palette_mode[0] ? clamped : ONE - clamped;
  end

  assign kprod = {{LEVEL_W{1'b0}}, f1} * {{FW{1'b0}}, cfg.level_count};

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    if (g == 0) begin : g_first
      assign div_in[g] = '{rem: k2, quo: '0};
    end else begin : g_next
      assign div_in[g] = div_q[g-1];
    end
    assign div_out[g] = div_step(div_in[g], divisor);
  end

  // Once k reaches (levels - 1) the quotient is at least one, so the level saturates.
  assign quo_shifted = div_q[DIV_STAGES-1].quo >> QX;

  always_comb begin
    if (!quant) begin
      fq_next = div_f[DIV_STAGES-1];
    end else if (div_sat[DIV_STAGES-1]) begin
      fq_next = ONE;
    end else begin
      fq_next = {1'b0, quo_shifted[FRAC_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < DIV_STAGES; i++) begin
        div_valid[i] <= 1'b0;
      end
    end else if (advance) begin
      valid1       <= in_valid;
      valid2       <= valid1;
      div_valid[0] <= valid2;
      for (int i = 1; i < DIV_STAGES; i++) begin
        div_valid[i] <= div_valid[i-1];
      end
      out_valid <= div_valid[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f1         <= f_next;
      f2         <= f1;
      k2         <= kprod[FRAC_BITS+LEVEL_W-1:FRAC_BITS];
      div_f[0]   <= f2;
      div_sat[0] <= (k2 >= divisor);
      for (int i = 0; i < DIV_STAGES; i++) begin
        div_q[i] <= div_out[i];
      end
      for (int i = 1; i < DIV_STAGES; i++) begin
        div_f[i]   <= div_f[i-1];
        div_sat[i] <= div_sat[i-1];
      end
      frac <= fq_next;
    end
  end

endmodule

@@ hdl/vrc_shape.sv @@
// Middle of the colour map pipeline: smoothstep curve and blend factor selection.
// Two multiplier stages build v^2 and v^3, a third picks the factor and stops. Uses vrc_pkg.
module vrc_shape
  import vrc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                in_valid,
  input  logic [FW-1:0]       frac,
  input  cfg_t                cfg,
  output logic                out_valid,
  output logic [FW-1:0]       t,
  output logic [COLOUR_W-1:0] colour_a,
  output logic [COLOUR_W-1:0] colour_b
);

  function automatic logic [FW-1:0] sat_one(input logic [FW+1:0] v);
    return (v > {2'b00, ONE}) ? ONE : v[FW-1:0];
  endfunction

  logic                quant;
  logic                lower_n;
  logic [FW-1:0]       v_n;
  logic [2*FW-1:0]     sq;
  logic [2*FW-1:0]     cube;

  logic                valid_a;
  logic                lower_a;
  logic [FW-1:0]       frac_a;
  logic [FW-1:0]       v_a;
  logic [FW-1:0]       v2_a;

  logic                valid_b;
  logic                lower_b;
  logic [FW-1:0]       frac_b;
  logic [FW-1:0]       v2_b;
  logic [FW-1:0]       v3_b;

  logic [FW+1:0]       smooth_raw;
  logic [FW-1:0]       smooth;
  logic [FW:0]         dbl_s;
  logic                upper;
  logic [FW-1:0]       t_next;
  logic [2*COLOUR_W-1:0] pair;

  assign quant   = cfg.level_count > 8'd1;
  assign lower_n = frac < HALF;
  assign v_n     = lower_n ? frac + HALF : frac - HALF;
  assign sq      = {{FW{1'b0}}, v_n} * {{FW{1'b0}}, v_n};
  assign cube    = {{FW{1'b0}}, v2_a} * {{FW{1'b0}}, v_a};

  always_comb begin
    smooth_raw = ({2'b00, v2_b} << 1) + {2'b00, v2_b} - ({2'b00, v3_b} << 1);
    smooth     = sat_one(smooth_raw);
    dbl_s      = {smooth, 1'b0};
    upper      = !lower_b;
    priority if (cfg.palette_mode[2:1] == PAL_BWB) begin
      t_next = frac_b;
      upper  = 1'b0;
    end else if (lower_b) begin
      if (quant) begin
        t_next = {frac_b[FW-2:0], 1'b0};
      end else if (dbl_s > {1'b0, ONE}) begin
        t_next = sat_one({1'b0, dbl_s - {1'b0, ONE}});
      end else begin
        t_next = '0;
      end
    end else begin
      if (quant) begin
        t_next = sat_one({1'b0, frac_b - HALF, 1'b0});
      end else begin
        t_next = sat_one({1'b0, dbl_s});
      end
    end
    pair = stop_pair(cfg.palette_mode[2:1], upper);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      valid_a   <= in_valid;
      valid_b   <= valid_a;
      out_valid <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lower_a  <= lower_n;
      frac_a   <= frac;
      v_a      <= v_n;
      v2_a     <= sq[FRAC_BITS+FW-1:FRAC_BITS];
      lower_b  <= lower_a;
      frac_b   <= frac_a;
      v2_b     <= v2_a;
      v3_b     <= cube[FRAC_BITS+FW-1:FRAC_BITS];
      t        <= t_next;
      colour_a <= pair[2*COLOUR_W-1:COLOUR_W];
      colour_b <= pair[COLOUR_W-1:0];
    end
  end

endmodule

@@ hdl/vrc_blend.sv @@
// Last stage of the colour map pipeline: blends two stop colours per channel
// and holds the result in the output register. Uses vrc_pkg.
module vrc_blend
  import vrc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                in_valid,
  input  logic [FW-1:0]       t,
  input  logic [COLOUR_W-1:0] colour_a,
  input  logic [COLOUR_W-1:0] colour_b,
  output logic                out_valid,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue
);

  // A falling channel rounds its step up, so the result is the floor of the exact blend.
  function automatic logic [7:0] blend_channel(input logic [FW-1:0] f, input logic [7:0] a,
                                                input logic [7:0] b);
    logic [7:0]    diff;
    logic [FW+7:0] p;
    logic [FW+7:0] pc;
    diff = (b >= a) ? b - a : a - b;
    p    = {8'b0, f} * {{FW{1'b0}}, diff};
    pc   = p + {8'b0, ONE - 1'b1};
    if (b >= a) begin
      return a + p[FRAC_BITS+7:FRAC_BITS];
    end
    return a - pc[FRAC_BITS+7:FRAC_BITS];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      red   <= blend_channel(t, colour_a[23:16], colour_b[23:16]);
      green <= blend_channel(t, colour_a[15:8], colour_b[15:8]);
      blue  <= blend_channel(t, colour_a[7:0], colour_b[7:0]);
    end
  end

endmodule

@@ hdl/value_to_rgb_colormap_top.sv @@
// Top level of the value-to-RGB colour map: configuration registers and pipeline control.
// Instantiates vrc_quant, vrc_shape and vrc_blend; uses vrc_pkg.
//
//   Channel   Signals                            Moves
//   input     in_valid, in_ready, sample_value   one Q2.16 sample per transaction
//   output    out_valid, out_ready, red/g/b      one colour per transaction
//   config    wr_en, wr_index, wr_data           register write, no handshake
//
// One sample is taken every clock while the output side keeps up; the pipeline depth is
// set by the quantizer's long divider, which yields four quotient bits per stage, and by
// the two multiplier stages of the curve.
// Synchronous reset clears the valid bits and both registers to zero.
// When a result waits at the output, the whole pipeline holds; nothing is dropped.
module value_to_rgb_colormap_top
  import vrc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [IN_W-1:0] sample_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             red,
  output logic [7:0]             green,
  output logic [7:0]             blue,
  input  logic                   wr_en,
  input  logic                   wr_index,
  input  logic [LEVEL_W-1:0]     wr_data
);

  cfg_t                cfg;
  logic                advance;
  logic                quant_valid;
  logic [FW-1:0]       quant_frac;
  logic                shape_valid;
  logic [FW-1:0]       shape_t;
  logic [COLOUR_W-1:0] shape_a;
  logic [COLOUR_W-1:0] shape_b;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      if (wr_index == REG_PALETTE_MODE) begin
        cfg.palette_mode <= wr_data[MODE_W-1:0];
      end else begin
        cfg.level_count <= wr_data;
      end
    end
  end

  vrc_quant u_quant (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .in_valid     (in_valid),
    .sample_value (sample_value),
    .cfg          (cfg),
    .out_valid    (quant_valid),
    .frac         (quant_frac)
  );

  vrc_shape u_shape (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (quant_valid),
    .frac      (quant_frac),
    .cfg       (cfg),
    .out_valid (shape_valid),
    .t         (shape_t),
    .colour_a  (shape_a),
    .colour_b  (shape_b)
  );

  vrc_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (shape_valid),
    .t         (shape_t),
    .colour_a  (shape_a),
    .colour_b  (shape_b),
    .out_valid (out_valid),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

`ifndef SYNTHESIS
  // The grey palettes only ever produce shades of grey.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && cfg.palette_mode[2:1] == PAL_BWB |-> red == green && green == blue)
    else $error("grey palette produced a coloured output");

  // Red-yellow into blue: full red with no blue, or red equal to green.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && cfg.palette_mode[2:1] == PAL_BYR |->
      (red == 8'hFF && blue == 8'h00) || (red == green))
    else $error("colour off the red-yellow-blue path");

  // Red-white-blue: each half keeps one channel saturated and the other two equal.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && cfg.palette_mode[2:1] == PAL_RWB |->
      (red == 8'hFF && green == blue) || (blue == 8'hFF && red == green))
    else $error("colour off the red-white-blue path");
`endif

endmodule
